FILE: hdl/ecsgw_pkg.sv
`timescale 1ns / 1ps

package ecsgw_pkg;

	// register indexes on the sound chip
	localparam logic [3:0] REG_IO_ENABLE = 4'd7;
	localparam logic [3:0] REG_PORT_B    = 4'd15;

	// port b line assignments
	localparam logic [7:0] LINE_STROBE   = 8'h04;
	localparam logic [7:0] LINE_DATA     = 8'h08;
	localparam logic [7:0] LINE_CLOCK    = 8'h10;
	localparam logic [7:0] LINE_MASK     = 8'h1C;
	localparam logic [7:0] IO_ENABLE_VAL = 8'hBF;
	localparam logic [7:0] BOOST_BIT     = 8'h40;

	// steps of one byte: enable, 16 bit writes, strobe low, strobe high
	localparam int unsigned STEPS_PER_BYTE = 19;
	localparam logic [4:0] STEP_ENABLE     = 5'd0;
	localparam logic [4:0] STEP_LAST_BIT   = 5'd16;
	localparam logic [4:0] STEP_STROBE_LO  = 5'd17;
	localparam logic [4:0] STEP_STROBE_HI  = 5'd18;

	localparam logic signed [4:0] DB_MAX = 5'sd12;
	localparam logic signed [4:0] DB_MIN = -5'sd12;

	// one pending command between front and back
	typedef struct packed {
		logic [7:0] band;
		logic [7:0] gain;
		logic [7:0] other;
	} job_t;

	// one register write
	typedef struct packed {
		logic [3:0] register;
		logic [7:0] value;
		logic       last;
	} wr_t;

	// signed db to gain code, clamped, boost bit for positive gains
	function automatic logic [7:0] db_to_code(input logic signed [4:0] db);
		logic signed [4:0] c;
		logic [4:0]        neg;
		logic [3:0]        mag;
		logic [7:0]        code;
		c = db;
		if (db > DB_MAX) begin
			c = DB_MAX;
		end else if (db < DB_MIN) begin
			c = DB_MIN;
		end
		neg = 5'(-c);
		mag = c[4] ? neg[3:0] : c[3:0];
		case (mag)
			4'd0:    code = 8'h00;
			4'd1:    code = 8'h20;
			4'd2:    code = 8'h10;
			4'd3:    code = 8'h08;
			4'd4:    code = 8'h04;
			4'd5:    code = 8'h02;
			4'd6:    code = 8'h12;
			4'd7:    code = 8'h2A;
			4'd8:    code = 8'h16;
			4'd9:    code = 8'h01;
			4'd10:   code = 8'h29;
			4'd11:   code = 8'h2D;
			4'd12:   code = 8'h2F;
			default: code = 8'h00;
		endcase
		if (!c[4] && (c != 5'sd0)) begin
			code = code | BOOST_BIT;
		end
		return code;
	endfunction

endpackage

FILE: hdl/eq_chip_serial_gain_writer.sv
`timescale 1ns / 1ps

// Serial gain loader for a graphic-equalizer chip on a sound chip's port B.
// Each accepted command produces 38 register writes: for the band byte and
// then the gain byte, one I/O-enable write (register 7, 0xBF), sixteen port B
// writes clocking the bits out LSB first, and a strobe low/high pair; the
// final write carries last_write. With command set, gain_db is clamped to
// +/-12 and mapped through the gain code table (boost bit for positive gains).
// The back-end sequencer issues one write per cycle while pop is held high;
// a QUEUE_DEPTH-entry command queue in front
// of the sequencer accepts further commands while a sequence is running.
// Results come out of a one-entry output register with empty/pop.

module eq_chip_serial_gain_writer #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              command,
	input  logic [7:0]        band,
	input  logic [7:0]        gain_byte,
	input  logic signed [4:0] gain_db,
	input  logic [7:0]        port_other_bits,
	output logic              empty,
	input  logic              pop,
	output logic [3:0]        sound_chip_register,
	output logic [7:0]        write_value,
	output logic              last_write
);

	logic            job_valid;
	logic            job_ready;
	ecsgw_pkg::job_t job;
	ecsgw_pkg::wr_t  wr;

	// front: classify commands and queue them
	ecsgw_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.command         (command),
		.band            (band),
		.gain_byte       (gain_byte),
		.gain_db         (gain_db),
		.port_other_bits (port_other_bits),
		.job_valid       (job_valid),
		.job_ready       (job_ready),
		.job             (job)
	);

	// back: write sequencer
	ecsgw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.empty     (empty),
		.pop       (pop),
		.wr        (wr)
	);

	assign sound_chip_register = wr.register;
	assign write_value         = wr.value;
	assign last_write          = wr.last;

endmodule

FILE: hdl/ecsgw_front.sv
`timescale 1ns / 1ps

module ecsgw_front #(
	parameter int unsigned DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              command,
	input  logic [7:0]        band,
	input  logic [7:0]        gain_byte,
	input  logic signed [4:0] gain_db,
	input  logic [7:0]        port_other_bits,
	output logic              job_valid,
	input  logic              job_ready,
	output ecsgw_pkg::job_t   job
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	ecsgw_pkg::job_t  slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             wr_en;
	logic             rd_en;
	ecsgw_pkg::job_t  new_job;

	// classify: pick raw gain or table code
	always_comb begin
		new_job.band  = band;
		new_job.gain  = command ? ecsgw_pkg::db_to_code(gain_db) : gain_byte;
		new_job.other = port_other_bits;
	end

	assign full      = (count_q == CNT_FULL);
	assign job_valid = (count_q != '0);
	assign job       = slot_q[rd_ptr_q];
	assign wr_en     = push && !full;
	assign rd_en     = job_valid && job_ready;

	// queue storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= new_job;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// fill count never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL) else $error("job queue overfilled");

	// a write while full is refused
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !rd_en |=> count_q == CNT_FULL) else $error("job queue count lost");

	// pointers advance together with the count
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q)) else $error("job queue pointers skewed");

endmodule

FILE: hdl/ecsgw_back.sv
`timescale 1ns / 1ps

module ecsgw_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	output logic            job_ready,
	input  ecsgw_pkg::job_t job,
	output logic            empty,
	input  logic            pop,
	output ecsgw_pkg::wr_t  wr
);

	logic            busy_q;
	logic            byte_sel_q;
	logic [4:0]      step_q;
	ecsgw_pkg::job_t job_q;
	logic            out_valid_q;
	ecsgw_pkg::wr_t  out_q;
	logic            advance;
	logic            final_step;
	logic [7:0]      cur_byte;
	logic [4:0]      step_m1;
	logic [2:0]      bit_idx;
	logic            data_bit;
	logic [7:0]      base;
	ecsgw_pkg::wr_t  next_wr;

	assign advance    = busy_q && (!out_valid_q || pop);
	assign final_step = byte_sel_q && (step_q == ecsgw_pkg::STEP_STROBE_HI);
	assign job_ready  = !busy_q || (advance && final_step);
	assign empty      = !out_valid_q;
	assign wr         = out_q;

	// current bit of the byte being shifted out
	always_comb begin
		cur_byte = byte_sel_q ? job_q.gain : job_q.band;
		step_m1  = step_q - 5'd1;
		bit_idx  = (step_q > ecsgw_pkg::STEP_LAST_BIT) ? 3'd7 : step_m1[3:1];
		data_bit = cur_byte[bit_idx];
		base     = (job_q.other & ~ecsgw_pkg::LINE_MASK)
		         | (data_bit ? ecsgw_pkg::LINE_DATA : 8'h00);
	end

	// write for the current step
	always_comb begin
		next_wr.register = ecsgw_pkg::REG_PORT_B;
		next_wr.last     = final_step;
		if (step_q == ecsgw_pkg::STEP_ENABLE) begin
			next_wr.register = ecsgw_pkg::REG_IO_ENABLE;
			next_wr.value    = ecsgw_pkg::IO_ENABLE_VAL;
		end else if (step_q == ecsgw_pkg::STEP_STROBE_LO) begin
			next_wr.value = base | ecsgw_pkg::LINE_CLOCK;
		end else if (step_q == ecsgw_pkg::STEP_STROBE_HI) begin
			next_wr.value = base | ecsgw_pkg::LINE_CLOCK | ecsgw_pkg::LINE_STROBE;
		end else begin
			next_wr.value = base | ecsgw_pkg::LINE_STROBE
			              | (step_m1[0] ? ecsgw_pkg::LINE_CLOCK : 8'h00);
		end
	end

	// job holding register
	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			job_q <= job;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= next_wr;
		end
	end

	// sequencer and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			byte_sel_q  <= 1'b0;
			step_q      <= ecsgw_pkg::STEP_ENABLE;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (job_valid && job_ready) begin
				busy_q     <= 1'b1;
				byte_sel_q <= 1'b0;
				step_q     <= ecsgw_pkg::STEP_ENABLE;
			end else if (advance) begin
				if (final_step) begin
					busy_q <= 1'b0;
				end else if (step_q == ecsgw_pkg::STEP_STROBE_HI) begin
					byte_sel_q <= 1'b1;
					step_q     <= ecsgw_pkg::STEP_ENABLE;
				end else begin
					step_q <= step_q + 5'd1;
				end
			end
		end
	end

	// step counter stays inside one byte sequence
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= ecsgw_pkg::STEP_STROBE_HI) else $error("step counter out of range");

	// enable writes always carry the enable value
	a_enable_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.register == ecsgw_pkg::REG_IO_ENABLE
		|-> out_q.value == ecsgw_pkg::IO_ENABLE_VAL) else $error("bad enable write");

	// the final write is a strobe-high on port b
	a_last_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.last |-> out_q.register == ecsgw_pkg::REG_PORT_B
		&& (out_q.value & ecsgw_pkg::LINE_STROBE) != 8'h00) else $error("bad last write");

	// a new job is only taken when the sequencer is free or finishing
	a_job_take: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !(advance && final_step) |-> !job_ready) else $error("job taken mid sequence");

endmodule

FILE: tb/eq_chip_serial_gain_writer_tb.sv
`timescale 1ns / 1ps

module eq_chip_serial_gain_writer_tb;

	// one expected register write
	typedef struct packed {
		logic [3:0] target;
		logic [7:0] value;
		logic       last;
	} port_write_t;

	// gain codes indexed by dB magnitude
	localparam logic [7:0] GAIN_CODES [0:12] = '{
		8'h00, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h12,
		8'h2A, 8'h16, 8'h01, 8'h29, 8'h2D, 8'h2F
	};
	localparam int IDLE_PERCENT = 23;
	localparam int RANDOM_ITEMS = 450;
	localparam int BURST_ITEMS  = 60;

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	logic              command;
	logic [7:0]        band;
	logic [7:0]        gain_byte;
	logic signed [4:0] gain_db;
	logic [7:0]        port_other_bits;
	logic              empty;
	logic              pop;
	logic [3:0]        sound_chip_register;
	logic [7:0]        write_value;
	logic              last_write;

	port_write_t expected_writes[$];
	int          fail_count;
	bit          no_idle;

	eq_chip_serial_gain_writer DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (push),
		.full               (full),
		.command            (command),
		.band               (band),
		.gain_byte          (gain_byte),
		.gain_db            (gain_db),
		.port_other_bits    (port_other_bits),
		.empty              (empty),
		.pop                (pop),
		.sound_chip_register(sound_chip_register),
		.write_value        (write_value),
		.last_write         (last_write)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// clamp dB to +/-12, look up the code, boost bit for positive gains
	function automatic logic [7:0] gain_code_for(logic signed [4:0] db);
		int level;
		level = db;
		if (level > ecsgw_pkg::DB_MAX) level = ecsgw_pkg::DB_MAX;
		if (level < ecsgw_pkg::DB_MIN) level = ecsgw_pkg::DB_MIN;
		if (level > 0) return GAIN_CODES[level] | ecsgw_pkg::BOOST_BIT;
		return GAIN_CODES[-level];
	endfunction

	function automatic void expect_write(logic [3:0] target, logic [7:0] value, logic last);
		port_write_t w;
		w.target = target;
		w.value  = value;
		w.last   = last;
		expected_writes.push_back(w);
	endfunction

	// enable, eight clocked data bits lsb first, strobe pulse
	function automatic void expect_byte_writes(logic [7:0] data, logic [7:0] other,
			bit final_byte);
		logic [7:0] lines;
		lines = ecsgw_pkg::LINE_STROBE | ecsgw_pkg::LINE_CLOCK
		      | (other & ~ecsgw_pkg::LINE_MASK);
		expect_write(ecsgw_pkg::REG_IO_ENABLE, ecsgw_pkg::IO_ENABLE_VAL, 1'b0);
		for (int i = 0; i < 8; i++) begin
			if (data[i]) begin
				lines = lines | ecsgw_pkg::LINE_DATA;
			end else begin
				lines = lines & ~ecsgw_pkg::LINE_DATA;
			end
			lines = lines & ~ecsgw_pkg::LINE_CLOCK;
			expect_write(ecsgw_pkg::REG_PORT_B, lines, 1'b0);
			lines = lines | ecsgw_pkg::LINE_CLOCK;
			expect_write(ecsgw_pkg::REG_PORT_B, lines, 1'b0);
		end
		lines = lines & ~ecsgw_pkg::LINE_STROBE;
		expect_write(ecsgw_pkg::REG_PORT_B, lines, 1'b0);
		lines = lines | ecsgw_pkg::LINE_STROBE;
		expect_write(ecsgw_pkg::REG_PORT_B, lines, final_byte);
	endfunction

	function automatic void predict_command_writes(logic cmd, logic [7:0] band_sel,
			logic [7:0] raw_gain, logic signed [4:0] db, logic [7:0] other);
		logic [7:0] gain;
		gain = cmd ? gain_code_for(db) : raw_gain;
		expect_byte_writes(band_sel, other, 1'b0);
		expect_byte_writes(gain, other, 1'b1);
	endfunction

	function automatic void note_failure(string msg);
		fail_count++;
		if (fail_count <= 10) $display("%t: %s", $realtime, msg);
	endfunction

	// send one command transaction, push stays high for a following one
	task automatic send_command(logic cmd, logic [7:0] band_sel, logic [7:0] raw_gain,
			logic signed [4:0] db, logic [7:0] other);
		while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push            <= 1'b1;
		command         <= cmd;
		band            <= band_sel;
		gain_byte       <= raw_gain;
		gain_db         <= db;
		port_other_bits <= other;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_command_writes(cmd, band_sel, raw_gain, db, other);
	endtask

	task automatic send_random_command();
		send_command(1'($urandom), 8'($urandom), 8'($urandom), 5'($urandom),
			8'($urandom));
	endtask

	// raw gain path, field extremes, ignored dB field
	task automatic test_raw_gain();
		send_command(1'b0, 8'h00, 8'h00, 5'sd0, 8'h00);
		send_command(1'b0, 8'hFF, 8'hFF, -5'sd16, 8'hFF);
		send_command(1'b0, 8'hA5, 8'h5A, 5'sd15, 8'hE3);
		send_command(1'b0, 8'h5A, 8'hA5, 5'sd7, 8'h1C);
		send_command(1'b0, 8'h01, 8'h80, -5'sd1, 8'h63);
	endtask

	// dB path across the table, clamp on both sides, ignored raw gain field
	task automatic test_db_gain();
		logic signed [4:0] db_points [15] = '{-5'sd16, -5'sd13, -5'sd12, -5'sd11, -5'sd7,
			-5'sd6, -5'sd1, 5'sd0, 5'sd1, 5'sd5, 5'sd9, 5'sd11, 5'sd12, 5'sd13, 5'sd15};
		foreach (db_points[i]) begin
			send_command(1'b1, 8'($urandom), 8'($urandom), db_points[i], 8'($urandom));
		end
	endtask

	// no idling on either side
	task automatic test_back_to_back();
		no_idle = 1'b1;
		repeat (BURST_ITEMS) send_random_command();
		no_idle = 1'b0;
	endtask

	task automatic test_random_traffic();
		repeat (RANDOM_ITEMS - BURST_ITEMS) send_random_command();
	endtask

	// check each write transaction and drive pop
	initial begin
		port_write_t w;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (expected_writes.size() == 0) begin
					note_failure($sformatf("unexpected write reg %0d value %02h last %0b",
						sound_chip_register, write_value, last_write));
				end else begin
					w = expected_writes.pop_front();
					if (sound_chip_register !== w.target)
						note_failure($sformatf("register: expected %0d, got %0d",
							w.target, sound_chip_register));
					if (write_value !== w.value)
						note_failure($sformatf("write_value: expected %02h, got %02h",
							w.value, write_value));
					if (last_write !== w.last)
						note_failure($sformatf("last_write: expected %0b, got %0b",
							w.last, last_write));
				end
			end
			pop <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// stimulus sequence
	initial begin
		fail_count      = 0;
		no_idle         = 1'b0;
		arst_n          = 1'b0;
		push            = 1'b0;
		command         = 1'b0;
		band            = 8'h00;
		gain_byte       = 8'h00;
		gain_db         = 5'sd0;
		port_other_bits = 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_raw_gain();
		test_db_gain();
		test_back_to_back();
		test_random_traffic();

		push <= 1'b0;
		while (expected_writes.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0) begin
			$display("eq_chip_serial_gain_writer regression: pass");
		end else begin
			$display("eq_chip_serial_gain_writer regression: fail");
		end
		$finish;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("eq_chip_serial_gain_writer regression: fail");
		$finish;
	end

endmodule
